@@ sv/quadratic_poly_coord_warp_top_macros.svh @@
// Assertion macros used by the warp top level.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef QUADRATIC_POLY_COORD_WARP_TOP_MACROS_SVH
`define QUADRATIC_POLY_COORD_WARP_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define QPCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qpcw assertion failed");

// Next-cycle implication, disabled in reset.
`define QPCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qpcw assertion failed");

`endif

@@ sv/qpcw_pkg.sv @@
// Types and constants of the quadratic coordinate warp.
// Used by qpcw_corner and quadratic_poly_coord_warp_top; no dependencies.
package qpcw_pkg;

  localparam int COEF_W   = 32;
  localparam int COORD_W  = 32;
  localparam int CFG_AW   = 3;
  localparam int STAGES   = 7;
  // Exact sum: up to 2^97 in magnitude, with margin
  localparam int ACC_W    = 100;

  // Binary point positions of the exact sum and its terms
  localparam int LIN_SH_PT   = 32;
  localparam int LIN_SH_RECT = 16;
  localparam int OFF_SH_PT   = 56;
  localparam int OFF_SH_RECT = 24;
  localparam int OUT_SH_PT   = 56;
  localparam int OUT_SH_RECT = 40;
  localparam int QUO_W       = ACC_W - OUT_SH_RECT;

  localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_AW-1:0] {
    REG_QUAD_XX = 3'd0,
    REG_QUAD_XY = 3'd1,
    REG_QUAD_YY = 3'd2,
    REG_LIN_X   = 3'd3,
    REG_LIN_Y   = 3'd4,
    REG_OFFSET  = 3'd5
  } reg_idx_e;

  // Coefficients of one output coordinate
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] e;
    logic signed [COEF_W-1:0] f;
  } coef_set_t;

endpackage

@@ sv/quadratic_poly_coord_warp_top.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   kind_i, first_x_i, first_y_i, second_x_i, second_y_i
// out      output     out_valid_o / out_stall_i out_first_x_o .. out_second_y_o, saturated_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Seven register stages: input, products, partial products, alignment, pair sums,
// full sum, round/clamp. One word enters every cycle unless an output stall backs up to the input.
// The 64x32 coefficient products, cut into two 32x32 partials, set the stage depth.
// Reset clears the valid bits and all six coefficient registers.
// Each stage loads when it is empty or the next one moves, so bubbles close up
// and an output stall backs up only as far as the pipe is full.
// Top level of the quadratic warp; instantiates two qpcw_corner, uses qpcw_pkg.
`include "quadratic_poly_coord_warp_top_macros.svh"

module quadratic_poly_coord_warp_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [qpcw_pkg::COORD_W-1:0] first_x_i,
  input  logic signed [qpcw_pkg::COORD_W-1:0] first_y_i,
  input  logic signed [qpcw_pkg::COORD_W-1:0] second_x_i,
  input  logic signed [qpcw_pkg::COORD_W-1:0] second_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [qpcw_pkg::COORD_W-1:0] out_first_x_o,
  output logic signed [qpcw_pkg::COORD_W-1:0] out_first_y_o,
  output logic signed [qpcw_pkg::COORD_W-1:0] out_second_x_o,
  output logic signed [qpcw_pkg::COORD_W-1:0] out_second_y_o,
  output logic                                saturated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qpcw_pkg::CFG_AW-1:0]         cfg_index_i,
  input  logic [63:0]                         cfg_data_i
);

  localparam int NS = qpcw_pkg::STAGES;

  logic [63:0] quad_xx_q, quad_xy_q, quad_yy_q, lin_x_q, lin_y_q, offset_q;
  logic [NS-1:0] valid_q;
  logic [NS:0]   adv;

  logic                                kind_q;
  logic signed [qpcw_pkg::COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;

  qpcw_pkg::coef_set_t [1:0] coefs;

  logic [1:0][qpcw_pkg::COORD_W-1:0] res0, res1;
  logic [1:0]                        sat0, sat1;
  logic                              kind0_out, kind1_out;

  // Coefficient registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_xx_q <= '0;
      quad_xy_q <= '0;
      quad_yy_q <= '0;
      lin_x_q   <= '0;
      lin_y_q   <= '0;
      offset_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qpcw_pkg::REG_QUAD_XX: quad_xx_q <= cfg_data_i;
        qpcw_pkg::REG_QUAD_XY: quad_xy_q <= cfg_data_i;
        qpcw_pkg::REG_QUAD_YY: quad_yy_q <= cfg_data_i;
        qpcw_pkg::REG_LIN_X:   lin_x_q   <= cfg_data_i;
        qpcw_pkg::REG_LIN_Y:   lin_y_q   <= cfg_data_i;
        qpcw_pkg::REG_OFFSET:  offset_q  <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // upper halves drive X, lower halves Y
  always_comb begin
    coefs[0].a = quad_xx_q[63:32];
    coefs[0].b = quad_xy_q[63:32];
    coefs[0].c = quad_yy_q[63:32];
    coefs[0].d = lin_x_q[63:32];
    coefs[0].e = lin_y_q[63:32];
    coefs[0].f = offset_q[63:32];
    coefs[1].a = quad_xx_q[31:0];
    coefs[1].b = quad_xy_q[31:0];
    coefs[1].c = quad_yy_q[31:0];
    coefs[1].d = lin_x_q[31:0];
    coefs[1].e = lin_y_q[31:0];
    coefs[1].f = offset_q[31:0];
  end

  // A stage advances when empty or when the stage after it advances
  always_comb begin
    adv[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Input stage
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      kind_q <= kind_i;
      x1_q   <= first_x_i;
      y1_q   <= first_y_i;
      x2_q   <= second_x_i;
      y2_q   <= second_y_i;
    end
  end

  qpcw_corner u_corner0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv[NS-1:0]),
    .kind_i (kind_q),
    .x_i    (x1_q),
    .y_i    (y1_q),
    .coef_i (coefs),
    .res_o  (res0),
    .sat_o  (sat0),
    .kind_o (kind0_out)
  );

  qpcw_corner u_corner1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv[NS-1:0]),
    .kind_i (kind_q),
    .x_i    (x2_q),
    .y_i    (y2_q),
    .coef_i (coefs),
    .res_o  (res1),
    .sat_o  (sat1),
    .kind_o (kind1_out)
  );

  // Point words carry no second corner: zero it and ignore its flags
  assign out_valid_o    = valid_q[NS-1];
  assign out_first_x_o  = res0[0];
  assign out_first_y_o  = res0[1];
  assign out_second_x_o = kind0_out ? res1[0] : '0;
  assign out_second_y_o = kind0_out ? res1[1] : '0;
  assign saturated_o    = (|sat0) || (kind0_out && (|sat1));

  `QPCW_ASSERT_NOW(a_corner_kind_match, out_valid_o, kind0_out == kind1_out)
  `QPCW_ASSERT_NOW(a_full_pipe_stalls, out_valid_o && out_stall_i && (&valid_q), in_stall_o)
  `QPCW_ASSERT_NEXT(a_held_stage_keeps_word, valid_q[3] && !adv[4], valid_q[3])
  `QPCW_ASSERT_NOW(a_sat_hits_rail, out_valid_o && saturated_o,
    out_first_x_o == qpcw_pkg::COORD_MAX || out_first_x_o == qpcw_pkg::COORD_MIN ||
    out_first_y_o == qpcw_pkg::COORD_MAX || out_first_y_o == qpcw_pkg::COORD_MIN ||
    out_second_x_o == qpcw_pkg::COORD_MAX || out_second_x_o == qpcw_pkg::COORD_MIN ||
    out_second_y_o == qpcw_pkg::COORD_MAX || out_second_y_o == qpcw_pkg::COORD_MIN)

endmodule

@@ sv/qpcw_corner.sv @@
// One corner of the warp: maps (x, y) to X and Y through six pipeline stages.
// Depends on qpcw_pkg; stage advance comes from the top level.
module qpcw_corner (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [qpcw_pkg::STAGES-1:0]                  adv_i,
  input  logic                                         kind_i,
  input  logic signed [qpcw_pkg::COORD_W-1:0]          x_i,
  input  logic signed [qpcw_pkg::COORD_W-1:0]          y_i,
  input  qpcw_pkg::coef_set_t [1:0]                    coef_i,
  output logic [1:0][qpcw_pkg::COORD_W-1:0]            res_o,
  output logic [1:0]                                   sat_o,
  output logic                                         kind_o
);

  localparam int AW = qpcw_pkg::ACC_W;
  localparam int QW = qpcw_pkg::QUO_W;
  localparam int CW = qpcw_pkg::COORD_W;

  // kind travels from stage 2 to stage 7
  logic [5:0] kind_q;

  logic signed [63:0]   prod_q [3];
  logic signed [63:0]   lx_q [2];
  logic signed [63:0]   ly_q [2];
  logic signed [63:0]   lx3_q [2];
  logic signed [63:0]   ly3_q [2];
  logic signed [64:0]   plo_q [2][3];
  logic signed [63:0]   phi_q [2][3];
  logic signed [AW-1:0] quad_q [2][3];
  logic signed [AW-1:0] lin_x_q [2];
  logic signed [AW-1:0] lin_y_q [2];
  logic signed [AW-1:0] off_q [2];
  logic signed [AW-1:0] sa_q [2];
  logic signed [AW-1:0] sb_q [2];
  logic signed [AW-1:0] sc_q [2];
  logic signed [AW-1:0] sum_q [2];
  logic [CW-1:0]        res_q [2];
  logic [1:0]           sat_q;

  logic signed [qpcw_pkg::COEF_W-1:0] quad_coef [2][3];
  logic [CW-1:0]                      res_d [2];
  logic [1:0]                         sat_d;
  logic [QW-1:0]                      quo [2];

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      quad_coef[o][0] = coef_i[o].a;
      quad_coef[o][1] = coef_i[o].b;
      quad_coef[o][2] = coef_i[o].c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0;
    end else begin
      if (adv_i[1]) kind_q[0] <= kind_i;
      for (int k = 1; k < 6; k++) begin
        if (adv_i[k+1]) kind_q[k] <= kind_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 2: coordinate products and linear terms
    if (adv_i[1]) begin
      prod_q[0] <= x_i * x_i;
      prod_q[1] <= x_i * y_i;
      prod_q[2] <= y_i * y_i;
      for (int o = 0; o < 2; o++) begin
        lx_q[o] <= coef_i[o].d * x_i;
        ly_q[o] <= coef_i[o].e * y_i;
      end
    end
    // stage 3: split each 64-bit product into two 32x32 partials
    if (adv_i[2]) begin
      for (int o = 0; o < 2; o++) begin
        for (int t = 0; t < 3; t++) begin
          plo_q[o][t] <= $signed({1'b0, prod_q[t][31:0]}) * quad_coef[o][t];
          phi_q[o][t] <= $signed(prod_q[t][63:32]) * quad_coef[o][t];
        end
        lx3_q[o] <= lx_q[o];
        ly3_q[o] <= ly_q[o];
      end
    end
    // stage 4: align every term to the binary point of the sum
    if (adv_i[3]) begin
      for (int o = 0; o < 2; o++) begin
        for (int t = 0; t < 3; t++) begin
          quad_q[o][t] <= (AW'(phi_q[o][t]) <<< 32) + AW'(plo_q[o][t]);
        end
        if (kind_q[1]) begin
          lin_x_q[o] <= AW'(lx3_q[o]) <<< qpcw_pkg::LIN_SH_RECT;
          lin_y_q[o] <= AW'(ly3_q[o]) <<< qpcw_pkg::LIN_SH_RECT;
          off_q[o]   <= (AW'(coef_i[o].f) <<< qpcw_pkg::OFF_SH_RECT)
                        + (qpcw_pkg::ACC_ONE <<< (qpcw_pkg::OUT_SH_RECT - 1));
        end else begin
          lin_x_q[o] <= AW'(lx3_q[o]) <<< qpcw_pkg::LIN_SH_PT;
          lin_y_q[o] <= AW'(ly3_q[o]) <<< qpcw_pkg::LIN_SH_PT;
          off_q[o]   <= (AW'(coef_i[o].f) <<< qpcw_pkg::OFF_SH_PT)
                        + (qpcw_pkg::ACC_ONE <<< (qpcw_pkg::OUT_SH_PT - 1));
        end
      end
    end
    // stage 5: pairwise sums
    if (adv_i[4]) begin
      for (int o = 0; o < 2; o++) begin
        sa_q[o] <= quad_q[o][0] + quad_q[o][1];
        sb_q[o] <= quad_q[o][2] + lin_x_q[o];
        sc_q[o] <= lin_y_q[o] + off_q[o];
      end
    end
    // stage 6: exact sum, half already included
    if (adv_i[5]) begin
      for (int o = 0; o < 2; o++) begin
        sum_q[o] <= sa_q[o] + sb_q[o] + sc_q[o];
      end
    end
    // stage 7: round and clamp
    if (adv_i[6]) begin
      for (int o = 0; o < 2; o++) begin
        res_q[o] <= res_d[o];
      end
      sat_q <= sat_d;
    end
  end

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      if (kind_q[4]) begin
        // truncate toward zero: bump a negative quotient that lost bits
        quo[o] = QW'(sum_q[o] >>> qpcw_pkg::OUT_SH_RECT)
                 + QW'(sum_q[o][AW-1] && (sum_q[o][qpcw_pkg::OUT_SH_RECT-1:0] != '0));
      end else begin
        quo[o] = QW'(sum_q[o] >>> qpcw_pkg::OUT_SH_PT);
      end
      if ((&quo[o][QW-1:CW-1]) || !(|quo[o][QW-1:CW-1])) begin
        res_d[o] = quo[o][CW-1:0];
        sat_d[o] = 1'b0;
      end else begin
        res_d[o] = quo[o][QW-1] ? qpcw_pkg::COORD_MIN : qpcw_pkg::COORD_MAX;
        sat_d[o] = 1'b1;
      end
    end
  end

  assign res_o[0] = res_q[0];
  assign res_o[1] = res_q[1];
  assign sat_o    = sat_q;
  assign kind_o   = kind_q[5];

endmodule

@@ verif/tb_top.sv @@
// Testbench for quadratic_poly_coord_warp_top: directed and random coordinate words,
// each checked against a 128-bit exact-sum predictor of the polynomial warp.
// Depends on qpcw_pkg and the warp RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_top;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_RECT  = 1'b1;
  // Indexes past the last register: writes to them must be dropped
  localparam logic [qpcw_pkg::CFG_AW-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [qpcw_pkg::CFG_AW-1:0] IDX_SPARE_B = 3'd7;

  // Binary points of the exact sum: point mode 2^-56, rectangle mode 2^-40
  localparam int PT_LIN_SHIFT   = 32;
  localparam int PT_OFF_SHIFT   = 56;
  localparam int PT_OUT_SHIFT   = 56;
  localparam int RECT_LIN_SHIFT = 16;
  localparam int RECT_OFF_SHIFT = 24;
  localparam int RECT_OUT_SHIFT = 40;

  localparam logic signed [127:0] WIDE_ONE = 128'sd1;
  localparam logic signed [127:0] WIDE_MAX = 128'(qpcw_pkg::COORD_MAX);
  localparam logic signed [127:0] WIDE_MIN = 128'(qpcw_pkg::COORD_MIN);

  localparam logic signed [31:0] C_MAX = qpcw_pkg::COORD_MAX;
  localparam logic signed [31:0] C_MIN = qpcw_pkg::COORD_MIN;

  localparam int SETTLE_CYCLES = qpcw_pkg::STAGES + 2;
  localparam int STUCK_LIMIT   = 2000;

  typedef logic [5:0][63:0] bank_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } warp_in_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic               sat;
  } warp_out_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic                                kind_i = 1'b0;
  logic signed [qpcw_pkg::COORD_W-1:0] first_x_i = '0;
  logic signed [qpcw_pkg::COORD_W-1:0] first_y_i = '0;
  logic signed [qpcw_pkg::COORD_W-1:0] second_x_i = '0;
  logic signed [qpcw_pkg::COORD_W-1:0] second_y_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [qpcw_pkg::COORD_W-1:0] out_first_x_o;
  logic signed [qpcw_pkg::COORD_W-1:0] out_first_y_o;
  logic signed [qpcw_pkg::COORD_W-1:0] out_second_x_o;
  logic signed [qpcw_pkg::COORD_W-1:0] out_second_y_o;
  logic                                saturated_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [qpcw_pkg::CFG_AW-1:0]         cfg_index_i = '0;
  logic [63:0]                         cfg_data_i = '0;

  bank_t     coef_shadow = '0;
  warp_out_t mapped_q[$];
  bit        calm = 1'b0;
  int        fault_cnt = 0;
  int        stuck_cycles = 0;

  quadratic_poly_coord_warp_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_first_x_o  (out_first_x_o),
    .out_first_y_o  (out_first_y_o),
    .out_second_x_o (out_second_x_o),
    .out_second_y_o (out_second_y_o),
    .saturated_o    (saturated_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- prediction ----------------

  // Exact polynomial sum for output X (sel_y = 0) or Y (sel_y = 1)
  function automatic logic signed [127:0] exact_sum(input bit sel_y,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y,
                                                    input bit frac);
    logic signed [127:0] cf [6];
    logic signed [31:0]  half;
    logic signed [127:0] xw;
    logic signed [127:0] yw;
    int                  lsh;
    int                  osh;
    for (int i = 0; i < 6; i++) begin
      half = sel_y ? coef_shadow[i][31:0] : coef_shadow[i][63:32];
      cf[i] = 128'(half);
    end
    xw = 128'(x);
    yw = 128'(y);
    lsh = frac ? PT_LIN_SHIFT : RECT_LIN_SHIFT;
    osh = frac ? PT_OFF_SHIFT : RECT_OFF_SHIFT;
    return xw * xw * cf[qpcw_pkg::REG_QUAD_XX] + xw * yw * cf[qpcw_pkg::REG_QUAD_XY]
           + yw * yw * cf[qpcw_pkg::REG_QUAD_YY]
           + ((cf[qpcw_pkg::REG_LIN_X] * xw) <<< lsh)
           + ((cf[qpcw_pkg::REG_LIN_Y] * yw) <<< lsh)
           + (cf[qpcw_pkg::REG_OFFSET] <<< osh);
  endfunction

  // Returns {clipped, value}
  function automatic logic [32:0] clip32(input logic signed [127:0] v);
    if (v > WIDE_MAX) return {1'b1, C_MAX};
    if (v < WIDE_MIN) return {1'b1, C_MIN};
    return {1'b0, v[31:0]};
  endfunction

  // Round to nearest, ties toward plus infinity
  function automatic logic [32:0] map_point(input bit sel_y, input logic signed [31:0] x,
                                            input logic signed [31:0] y);
    logic signed [127:0] t;
    t = exact_sum(sel_y, x, y, 1'b1) + (WIDE_ONE <<< (PT_OUT_SHIFT - 1));
    return clip32(t >>> PT_OUT_SHIFT);
  endfunction

  // Add one half, then truncate toward zero
  function automatic logic [32:0] map_corner(input bit sel_y, input logic signed [31:0] x,
                                             input logic signed [31:0] y);
    logic signed [127:0] t;
    t = exact_sum(sel_y, x, y, 1'b0) + (WIDE_ONE <<< (RECT_OUT_SHIFT - 1));
    if (t < 0) t = -((-t) >>> RECT_OUT_SHIFT);
    else t = t >>> RECT_OUT_SHIFT;
    return clip32(t);
  endfunction

  function automatic warp_out_t warp_predict(input warp_in_t w);
    warp_out_t   r;
    logic [32:0] c0;
    logic [32:0] c1;
    logic [32:0] c2;
    logic [32:0] c3;
    if (w.kind == KIND_POINT) begin
      c0 = map_point(1'b0, w.x1, w.y1);
      c1 = map_point(1'b1, w.x1, w.y1);
      c2 = '0;
      c3 = '0;
    end else begin
      c0 = map_corner(1'b0, w.x1, w.y1);
      c1 = map_corner(1'b1, w.x1, w.y1);
      c2 = map_corner(1'b0, w.x2, w.y2);
      c3 = map_corner(1'b1, w.x2, w.y2);
    end
    r.x1  = c0[31:0];
    r.y1  = c1[31:0];
    r.x2  = c2[31:0];
    r.y2  = c3[31:0];
    r.sat = c0[32] | c1[32] | c2[32] | c3[32];
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 27);
  endfunction

  // Random value of random magnitude, both signs
  function automatic logic signed [31:0] rand_scaled(input int lo);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(31, lo);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? C_MAX : C_MIN;
      2, 3: return rand_scaled(0);
      default: return rand_scaled(12);
    endcase
  endfunction

  function automatic bank_t rand_bank();
    bank_t b;
    for (int i = 0; i < 6; i++) b[i] = {rand_scaled($urandom_range(0, 16)),
                                        rand_scaled($urandom_range(0, 16))};
    return b;
  endfunction

  function automatic warp_in_t mk(input logic kind, input logic signed [31:0] x1,
                                  input logic signed [31:0] y1, input logic signed [31:0] x2,
                                  input logic signed [31:0] y2);
    warp_in_t w;
    w.kind = kind;
    w.x1 = x1;
    w.y1 = y1;
    w.x2 = x2;
    w.y2 = y2;
    return w;
  endfunction

  // Send one word; valid stays high after acceptance
  task automatic push_coords(input warp_in_t w);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      kind_i     <= 1'($urandom_range(0, 1));
      first_x_i  <= $urandom;
      first_y_i  <= $urandom;
      second_x_i <= $urandom;
      second_y_i <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= w.kind;
    first_x_i  <= w.x1;
    first_y_i  <= w.y1;
    second_x_i <= w.x2;
    second_y_i <= w.y2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mapped_q.push_back(warp_predict(w));
  endtask

  // Drop valid, wait for every pending result, then let the pipe settle
  task automatic wait_mapped_drained();
    in_valid_i <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it
  task automatic put_reg(input logic [qpcw_pkg::CFG_AW-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx <= qpcw_pkg::REG_OFFSET) coef_shadow[idx] = data;
  endtask

  task automatic apply_bank(input bank_t b, input bit poke_spare);
    wait_mapped_drained();
    for (int i = int'(qpcw_pkg::REG_QUAD_XX); i <= int'(qpcw_pkg::REG_OFFSET); i++)
      put_reg(qpcw_pkg::CFG_AW'(i), b[i]);
    if (poke_spare) begin
      put_reg(IDX_SPARE_A, {$urandom, $urandom});
      put_reg(IDX_SPARE_B, {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------- tests ----------------

  // Registers at reset value: every result is zero
  task automatic test_reset_state();
    push_coords(mk(KIND_POINT, 32'sd0, C_MAX, C_MIN, $urandom));
    push_coords(mk(KIND_RECT, C_MIN, C_MAX, C_MAX, C_MIN));
    push_coords(mk(KIND_POINT, C_MIN, C_MIN, C_MAX, C_MAX));
  endtask

  // Unit linear terms; spare indexes written with junk must not disturb them
  task automatic test_identity();
    bank_t b;
    b = '0;
    b[qpcw_pkg::REG_LIN_X] = {32'h0100_0000, 32'h0000_0000};
    b[qpcw_pkg::REG_LIN_Y] = {32'h0000_0000, 32'h0100_0000};
    apply_bank(b, 1'b1);
    push_coords(mk(KIND_POINT, C_MAX, C_MIN, $urandom, $urandom));
    push_coords(mk(KIND_POINT, 32'sd12345, -32'sd6789, $urandom, $urandom));
    push_coords(mk(KIND_RECT, -32'sd3, 32'sd5, C_MAX, C_MIN));
    push_coords(mk(KIND_RECT, 32'sd0, 32'sd0, -32'sd1, 32'sd1));
  endtask

  // Half-LSB ties in point mode, add-half-and-truncate in rectangle mode
  task automatic test_rounding();
    bank_t b;
    b = '0;
    b[qpcw_pkg::REG_LIN_X] = {32'h0080_0000, 32'h0000_0000};
    b[qpcw_pkg::REG_LIN_Y] = {32'h0000_0000, 32'h0080_0000};
    apply_bank(b, 1'b0);
    push_coords(mk(KIND_POINT, 32'sd1, 32'sd1, $urandom, $urandom));
    push_coords(mk(KIND_POINT, -32'sd1, -32'sd1, $urandom, $urandom));
    push_coords(mk(KIND_POINT, 32'sd3, -32'sd3, $urandom, $urandom));
    push_coords(mk(KIND_RECT, 32'sd1, -32'sd1, 32'sd3, -32'sd3));
    push_coords(mk(KIND_RECT, -32'sd2, 32'sd2, -32'sd5, 32'sd5));
    // Offsets of -0.75 and -1.5 with a small cross term
    b = '0;
    b[qpcw_pkg::REG_QUAD_XY] = {32'h0000_1000, 32'hFFFF_F000};
    b[qpcw_pkg::REG_OFFSET]  = {32'hFFFF_4000, 32'hFFFE_8000};
    apply_bank(b, 1'b0);
    push_coords(mk(KIND_RECT, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    push_coords(mk(KIND_POINT, 32'sd0, 32'sd0, $urandom, $urandom));
    push_coords(mk(KIND_RECT, 32'sd2, -32'sd3, -32'sd5, 32'sd7));
  endtask

  // Full-scale coefficients drive the sum past both rails
  task automatic test_saturation();
    bank_t b;
    b = {6{64'h7FFF_FFFF_7FFF_FFFF}};
    apply_bank(b, 1'b0);
    push_coords(mk(KIND_POINT, C_MAX, C_MAX, $urandom, $urandom));
    push_coords(mk(KIND_POINT, C_MIN, C_MAX, $urandom, $urandom));
    push_coords(mk(KIND_RECT, C_MIN, C_MIN, C_MAX, 32'sd0));
    push_coords(mk(KIND_RECT, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    b = {6{64'h8000_0000_8000_0000}};
    apply_bank(b, 1'b0);
    push_coords(mk(KIND_POINT, C_MAX, C_MAX, $urandom, $urandom));
    push_coords(mk(KIND_POINT, C_MIN, C_MAX, $urandom, $urandom));
    push_coords(mk(KIND_RECT, C_MIN, C_MIN, C_MAX, 32'sd0));
    push_coords(mk(KIND_RECT, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    b = {6{64'h7FFF_FFFF_8000_0000}};
    apply_bank(b, 1'b0);
    push_coords(mk(KIND_POINT, 32'sd65536, -32'sd65536, $urandom, $urandom));
  endtask

  // Several coefficient banks, each followed by a burst of random words
  task automatic test_random_traffic();
    bank_t b;
    for (int p = 0; p < 7; p++) begin
      case (p)
        2: b = {6{64'h7FFF_FFFF_8000_0000}};
        3: b = {6{64'h8000_0000_7FFF_FFFF}};
        5: begin
          b = rand_bank();
          b[qpcw_pkg::REG_QUAD_XX] = '0;
          b[qpcw_pkg::REG_QUAD_XY] = '0;
          b[qpcw_pkg::REG_QUAD_YY] = '0;
        end
        default: b = rand_bank();
      endcase
      apply_bank(b, p[0]);
      calm = (p == 4);
      for (int n = 0; n < 64; n++) begin
        // Hold the sender once until the pipe has emptied
        if (p == 1 && n == 32) wait_mapped_drained();
        push_coords(mk(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord()));
      end
      calm = 1'b0;
    end
  endtask

  // ---------------- result checking and watchdog ----------------

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk_i) begin
    warp_out_t seen_w;
    warp_out_t want_w;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_top: no progress for %0d cycles", STUCK_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end else if (out_valid_o && !out_stall_i) begin
        seen_w = '{out_first_x_o, out_first_y_o, out_second_x_o, out_second_y_o, saturated_o};
        if (mapped_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("tb_top: unexpected result x1=%0d y1=%0d x2=%0d y2=%0d sat=%0b",
                     seen_w.x1, seen_w.y1, seen_w.x2, seen_w.y2, seen_w.sat);
        end else begin
          want_w = mapped_q.pop_front();
          if (seen_w.x1 !== want_w.x1 || seen_w.y1 !== want_w.y1 ||
              seen_w.x2 !== want_w.x2 || seen_w.y2 !== want_w.y2 ||
              seen_w.sat !== want_w.sat) begin
            fault_cnt++;
            if (fault_cnt <= 10)
              $display("tb_top: mismatch exp x1=%0d y1=%0d x2=%0d y2=%0d sat=%0b %s",
                       want_w.x1, want_w.y1, want_w.x2, want_w.y2, want_w.sat,
                       $sformatf("got x1=%0d y1=%0d x2=%0d y2=%0d sat=%0b",
                                 seen_w.x1, seen_w.y1, seen_w.x2, seen_w.y2, seen_w.sat));
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_identity();
    test_rounding();
    test_saturation();
    test_random_traffic();
    wait_mapped_drained();
    if (fault_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/qpcw_pkg.sv
sv/qpcw_corner.sv
sv/quadratic_poly_coord_warp_top.sv
verif/tb_top.sv
